// ===== rtl/core/rank_clip_denoise_3x3_core_assert.svh =====
// ----------------------------------------------------------------------------
// rank_clip_denoise_3x3_core_assert.svh
// Assertion macros of the core, included by rcd3_emit.
// ----------------------------------------------------------------------------
`ifndef RANK_CLIP_DENOISE_3X3_CORE_ASSERT_SVH
`define RANK_CLIP_DENOISE_3X3_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define RCD3_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define RCD3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rcd3_pkg.sv =====
// ----------------------------------------------------------------------------
// rcd3_pkg
// Types and constants of the 3x3 rank-clip denoise core.
// ----------------------------------------------------------------------------
package rcd3_pkg;

    // Input transfer: one column slice
    typedef struct packed {
        logic [15:0] pixel_above;
        logic [15:0] pixel_center;
        logic [15:0] pixel_below;
        logic        border_row;
        logic        row_end;
    } t_in;

    // Output transfer: one filtered pixel
    typedef struct packed {
        logic [15:0] pixel_out;
        logic        last_of_row;
    } t_out;

    // Control part of a job travelling from front to back
    typedef struct packed {
        logic a_v;   // delayed result of the previous column present
        logic filt;  // delayed result is filtered, else its centre passes
        logic b_v;   // row-end pass-through result present
    } t_job_ctl;

    // Pixel slots of a job: eight neighbours, then centre, then pass-through
    localparam int NEIGHBOURS  = 8;
    localparam int CENTER_SLOT = 8;
    localparam int PASS_SLOT   = 9;
    localparam int SLOTS       = 10;

    // Clip rank range and the top neighbour index
    localparam logic [2:0] RANK_MIN = 3'd1;
    localparam logic [2:0] RANK_MAX = 3'd4;
    localparam logic [2:0] RANK_TOP = 3'd7;

    // Odd-even merge network for eight values, in comparator order
    localparam int NET_LEN = 19;
    localparam logic [2:0] NET_LO [NET_LEN] =
        '{3'd0, 3'd2, 3'd4, 3'd6, 3'd0, 3'd1, 3'd4, 3'd5, 3'd1, 3'd5,
          3'd0, 3'd1, 3'd2, 3'd3, 3'd2, 3'd3, 3'd1, 3'd3, 3'd5};
    localparam logic [2:0] NET_HI [NET_LEN] =
        '{3'd1, 3'd3, 3'd5, 3'd7, 3'd2, 3'd3, 3'd6, 3'd7, 3'd2, 3'd6,
          3'd4, 3'd5, 3'd6, 3'd7, 3'd4, 3'd5, 3'd2, 3'd4, 3'd6};

    // Last comparator of each pipeline stage (two network layers per stage)
    localparam int CUT1_LAST = 7;
    localparam int CUT2_LAST = 13;
    localparam int CUT3_LAST = 18;

endpackage

// ===== rtl/core/rcd3_front.sv =====
// ----------------------------------------------------------------------------
// rcd3_front
// Accepts column slices, holds the 3x3 window and issues one job per
// transfer that produces results.
// ----------------------------------------------------------------------------
module rcd3_front #(
    parameter int PIXEL_BITS = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_in_valid,
    output logic                                         o_in_ready,
    input  rcd3_pkg::t_in                                i_in_data,
    input  logic                                         i_q_full,
    output logic                                         o_push,
    output rcd3_pkg::t_job_ctl                           o_job_ctl,
    output logic [rcd3_pkg::SLOTS-1:0][PIXEL_BITS-1:0]   o_job_pix
);

    logic [2:0][PIXEL_BITS-1:0] r_prev;
    logic [2:0][PIXEL_BITS-1:0] r_older;
    logic [1:0]                 r_cols;
    logic [1:0]                 n_cols;
    logic                       r_border;
    logic [2:0][PIXEL_BITS-1:0] cur;
    logic                       accept;

    // Keep the low pixel bits of the slice
    assign cur[0] = i_in_data.pixel_above[PIXEL_BITS-1:0];
    assign cur[1] = i_in_data.pixel_center[PIXEL_BITS-1:0];
    assign cur[2] = i_in_data.pixel_below[PIXEL_BITS-1:0];

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;

    // Classify the transfer
    assign o_job_ctl.a_v  = (r_cols != 2'd0);
    assign o_job_ctl.filt = (r_cols == 2'd2) && !r_border;
    assign o_job_ctl.b_v  = i_in_data.row_end;
    assign o_push         = accept && (o_job_ctl.a_v || o_job_ctl.b_v);

    // Assemble the window around the previous column
    assign o_job_pix[0]                     = r_older[0];
    assign o_job_pix[1]                     = r_older[1];
    assign o_job_pix[2]                     = r_older[2];
    assign o_job_pix[3]                     = r_prev[0];
    assign o_job_pix[4]                     = r_prev[2];
    assign o_job_pix[5]                     = cur[0];
    assign o_job_pix[6]                     = cur[1];
    assign o_job_pix[7]                     = cur[2];
    assign o_job_pix[rcd3_pkg::CENTER_SLOT] = r_prev[1];
    assign o_job_pix[rcd3_pkg::PASS_SLOT]   = cur[1];

    // Count held columns, saturating at two, clear at row end
    always_comb begin
        if (i_in_data.row_end) begin
            n_cols = 2'd0;
        end else if (r_cols == 2'd2) begin
            n_cols = 2'd2;
        end else begin
            n_cols = r_cols + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols   <= 2'd0;
            r_border <= 1'b0;
        end else if (accept) begin
            r_cols   <= n_cols;
            r_border <= i_in_data.border_row;
        end
    end

    // Shift the slices
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_older <= r_prev;
            r_prev  <= cur;
        end
    end

endmodule

// ===== rtl/core/rcd3_queue.sv =====
// ----------------------------------------------------------------------------
// rcd3_queue
// Short show-ahead queue of jobs between the front and the sorting pipeline.
// ----------------------------------------------------------------------------
module rcd3_queue #(
    parameter int PIXEL_BITS = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_push,
    input  rcd3_pkg::t_job_ctl                           i_ctl,
    input  logic [rcd3_pkg::SLOTS-1:0][PIXEL_BITS-1:0]   i_pix,
    output logic                                         o_full,
    output logic                                         o_valid,
    input  logic                                         i_pop,
    output rcd3_pkg::t_job_ctl                           o_ctl,
    output logic [rcd3_pkg::SLOTS-1:0][PIXEL_BITS-1:0]   o_pix
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    rcd3_pkg::t_job_ctl                         r_ctl [DEPTH];
    logic [rcd3_pkg::SLOTS-1:0][PIXEL_BITS-1:0] r_pix [DEPTH];
    logic [PTR_W-1:0]                           r_wr;
    logic [PTR_W-1:0]                           r_rd;
    logic [CNT_W-1:0]                           r_cnt;
    logic                                       do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign do_pop  = i_pop && o_valid;
    assign o_ctl   = r_ctl[r_rd];
    assign o_pix   = r_pix[r_rd];

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    // Store the job
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ctl[r_wr] <= i_ctl;
            r_pix[r_wr] <= i_pix;
        end
    end

endmodule

// ===== rtl/core/rcd3_sort.sv =====
// ----------------------------------------------------------------------------
// rcd3_sort
// Three-stage pipelined sorting network for the eight neighbours; two
// network layers per stage. Centre and pass-through pixels ride along.
// ----------------------------------------------------------------------------
module rcd3_sort #(
    parameter int PIXEL_BITS = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_valid,
    output logic                                         o_ready,
    input  rcd3_pkg::t_job_ctl                           i_ctl,
    input  logic [rcd3_pkg::SLOTS-1:0][PIXEL_BITS-1:0]   i_pix,
    output logic                                         o_valid,
    input  logic                                         i_ready,
    output rcd3_pkg::t_job_ctl                           o_ctl,
    output logic [rcd3_pkg::SLOTS-1:0][PIXEL_BITS-1:0]   o_pix
);

    typedef logic [rcd3_pkg::SLOTS-1:0][PIXEL_BITS-1:0] t_pix;

    // Apply the comparators with index from first to last
    function automatic t_pix net_range(input t_pix v, input int first, input int last);
        t_pix                  w;
        logic [PIXEL_BITS-1:0] x;
        logic [PIXEL_BITS-1:0] y;
        w = v;
        for (int i = 0; i < rcd3_pkg::NET_LEN; i++) begin
            if (i >= first && i <= last) begin
                x = w[{1'b0, rcd3_pkg::NET_LO[i]}];
                y = w[{1'b0, rcd3_pkg::NET_HI[i]}];
                w[{1'b0, rcd3_pkg::NET_LO[i]}] = (x < y) ? x : y;
                w[{1'b0, rcd3_pkg::NET_HI[i]}] = (x < y) ? y : x;
            end
        end
        return w;
    endfunction

    logic               r_v1, r_v2, r_v3;
    rcd3_pkg::t_job_ctl r_c1, r_c2, r_c3;
    t_pix               r_p1, r_p2, r_p3;
    logic               rdy1, rdy2, rdy3;

    // Stall chain from the output back
    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v3;
    assign o_ctl   = r_c3;
    assign o_pix   = r_p3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Advance the network stages
    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_c1 <= i_ctl;
            r_p1 <= net_range(i_pix, 0, rcd3_pkg::CUT1_LAST);
        end
        if (rdy2) begin
            r_c2 <= r_c1;
            r_p2 <= net_range(r_p1, rcd3_pkg::CUT1_LAST + 1, rcd3_pkg::CUT2_LAST);
        end
        if (rdy3) begin
            r_c3 <= r_c2;
            r_p3 <= net_range(r_p2, rcd3_pkg::CUT2_LAST + 1, rcd3_pkg::CUT3_LAST);
        end
    end

endmodule

// ===== rtl/core/rcd3_emit.sv =====
// ----------------------------------------------------------------------------
// rcd3_emit
// Clamps the centre of filtered jobs between the selected ranks; sends up
// to two results per job via the output register, one per unstalled cycle.
// ----------------------------------------------------------------------------
`include "rank_clip_denoise_3x3_core_assert.svh"

module rcd3_emit #(
    parameter int PIXEL_BITS = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_cfg_wr_en,
    input  logic [2:0]                                   i_cfg_wr_data,
    input  logic                                         i_valid,
    output logic                                         o_ready,
    input  rcd3_pkg::t_job_ctl                           i_ctl,
    input  logic [rcd3_pkg::SLOTS-1:0][PIXEL_BITS-1:0]   i_pix,
    output logic                                         o_out_valid,
    input  logic                                         i_out_ready,
    output rcd3_pkg::t_out                               o_out_data
);

    logic [1:0]            r_sel;
    logic [1:0]            n_sel;
    logic                  r_out_v;
    rcd3_pkg::t_out        r_out;
    logic                  r_sec_v;
    logic [PIXEL_BITS-1:0] r_sec_pix;
    logic                  out_free;
    logic                  take;
    logic                  take_two;
    logic [PIXEL_BITS-1:0] lo_pix;
    logic [PIXEL_BITS-1:0] hi_pix;
    logic [PIXEL_BITS-1:0] ctr_pix;
    logic [PIXEL_BITS-1:0] clamp_pix;
    logic [PIXEL_BITS-1:0] a_pix;

    // Turn the written rank into a lower-neighbour index, clipped to range
    always_comb begin
        if (i_cfg_wr_data < rcd3_pkg::RANK_MIN) begin
            n_sel = 2'(rcd3_pkg::RANK_MIN - rcd3_pkg::RANK_MIN);
        end else if (i_cfg_wr_data > rcd3_pkg::RANK_MAX) begin
            n_sel = 2'(rcd3_pkg::RANK_MAX - rcd3_pkg::RANK_MIN);
        end else begin
            n_sel = 2'(i_cfg_wr_data - rcd3_pkg::RANK_MIN);
        end
    end

    // Clamp the centre between ranks n and 9-n
    assign lo_pix    = i_pix[{2'b00, r_sel}];
    assign hi_pix    = i_pix[{1'b0, rcd3_pkg::RANK_TOP - {1'b0, r_sel}}];
    assign ctr_pix   = i_pix[rcd3_pkg::CENTER_SLOT];
    assign clamp_pix = (ctr_pix < lo_pix) ? lo_pix : ((ctr_pix > hi_pix) ? hi_pix : ctr_pix);
    assign a_pix     = i_ctl.filt ? clamp_pix : ctr_pix;

    // Take a job only when no second result is waiting
    assign out_free    = !r_out_v || i_out_ready;
    assign take        = i_valid && out_free && !r_sec_v;
    assign take_two    = take && i_ctl.a_v && i_ctl.b_v;
    assign o_ready     = out_free && !r_sec_v;
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel   <= 2'd0;
            r_out_v <= 1'b0;
            r_sec_v <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_sel <= n_sel;
            end
            if (out_free) begin
                if (r_sec_v) begin
                    r_out_v <= 1'b1;
                    r_sec_v <= 1'b0;
                end else if (i_valid) begin
                    r_out_v <= 1'b1;
                    r_sec_v <= i_ctl.a_v && i_ctl.b_v;
                end else begin
                    r_out_v <= 1'b0;
                end
            end
        end
    end

    // Load the output transfer and hold the row-end result behind it
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_sec_v) begin
                r_out.pixel_out   <= 16'(r_sec_pix);
                r_out.last_of_row <= 1'b1;
            end else if (i_valid) begin
                if (i_ctl.a_v) begin
                    r_out.pixel_out   <= 16'(a_pix);
                    r_out.last_of_row <= 1'b0;
                    r_sec_pix         <= i_pix[rcd3_pkg::PASS_SLOT];
                end else begin
                    r_out.pixel_out   <= 16'(i_pix[rcd3_pkg::PASS_SLOT]);
                    r_out.last_of_row <= 1'b1;
                end
            end
        end
    end

    `RCD3_ASSERT_SAME(a_sec_behind_out, i_clk, i_rst_n, r_sec_v, r_out_v, "orphan second result")
    `RCD3_ASSERT_NEXT(a_two_results, i_clk, i_rst_n, take_two, r_sec_v, "row end not held")
    `RCD3_ASSERT_SAME(a_last_order, i_clk, i_rst_n, r_sec_v, !r_out.last_of_row, "row end first")

endmodule

// ===== rtl/core/rank_clip_denoise_3x3_core.sv =====
// ----------------------------------------------------------------------------
// rank_clip_denoise_3x3_core
// Streaming 3x3 rank-clip denoiser: sorts the eight neighbours of each
// interior pixel and clamps the centre between ranks n and 9-n.
//
//   Port group        Direction  Handshake                  Payload
//   input slices      in         i_in_valid / o_in_ready    i_in_data  (t_in)
//   filtered pixels   out        o_out_valid / i_out_ready  o_out_data (t_out)
//   clip rank         in         i_cfg_wr_en                i_cfg_wr_data
//
// One slice is accepted per cycle while the job queue is not full; results
// leave at one per cycle while i_out_ready holds. A row of W columns gives
// W results for W slices, the row-end slice giving two when W is above one.
// A result passes from the slice that releases it through the job queue,
// the three stages of the comparator network, then the output register.
// The four-entry job queue absorbs the second result of a row end and output
// stalls; o_in_ready drops only when that queue is full.
// Reset is synchronous and clears the held-column count and sets the rank to 1.
// ----------------------------------------------------------------------------
module rank_clip_denoise_3x3_core #(
    parameter int PIXEL_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rcd3_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output rcd3_pkg::t_out o_out_data,
    input  logic           i_cfg_wr_en,
    input  logic [2:0]     i_cfg_wr_data
);

    typedef logic [rcd3_pkg::SLOTS-1:0][PIXEL_BITS-1:0] t_pix;

    logic               push, q_full, q_valid, q_pop;
    rcd3_pkg::t_job_ctl f_ctl, q_ctl, s_ctl;
    t_pix               f_pix, q_pix, s_pix;
    logic               s_valid, s_ready;

    // Accept and classify slices
    rcd3_front #(.PIXEL_BITS(PIXEL_BITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_job_ctl  (f_ctl),
        .o_job_pix  (f_pix)
    );

    // Decouple front and back
    rcd3_queue #(.PIXEL_BITS(PIXEL_BITS)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ctl   (f_ctl),
        .i_pix   (f_pix),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_ctl   (q_ctl),
        .o_pix   (q_pix)
    );

    // Sort the neighbours
    rcd3_sort #(.PIXEL_BITS(PIXEL_BITS)) u_sort (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_pop),
        .i_ctl   (q_ctl),
        .i_pix   (q_pix),
        .o_valid (s_valid),
        .i_ready (s_ready),
        .o_ctl   (s_ctl),
        .o_pix   (s_pix)
    );

    // Clamp and send results
    rcd3_emit #(.PIXEL_BITS(PIXEL_BITS)) u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (s_valid),
        .o_ready       (s_ready),
        .i_ctl         (s_ctl),
        .i_pix         (s_pix),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_data    (o_out_data)
    );

endmodule
